/* sv/bsnt_pkg.sv */
package bsnt_pkg;

  localparam int EntriesPerBank = 64;
  localparam int NumBanks = 9;
  localparam int TotalEntries = NumBanks * EntriesPerBank;
  localparam int AddrW = $clog2(TotalEntries);
  localparam int PosW = $clog2(EntriesPerBank);
  localparam int CntW = $clog2(EntriesPerBank + 1);
  localparam int BankW = 4;
  localparam int EntryW = 64 + 64 + 32 + 32;
  localparam logic [BankW-1:0] OtherBank = 4'd8;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef logic [EntryW-1:0] entry_t;

  // Zero every byte after the first zero byte of the 20-byte name.
  function automatic logic [159:0] clean_name(input logic [159:0] n);
    logic [159:0] r;
    logic ended;
    r = n;
    ended = 1'b0;
    for (int i = 0; i < 20; i++) begin
      if (ended) begin
        r[159-8*i -: 8] = 8'd0;
      end else if (n[159-8*i -: 8] == 8'd0) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [BankW-1:0] pick_bank(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (c >= 8'h61 && c <= 8'h7a) begin
      c = c - 8'h20;
    end
    if (c inside {[8'h41:8'h43]}) return 4'd0;
    if (c inside {[8'h44:8'h46]}) return 4'd1;
    if (c inside {[8'h47:8'h4a]}) return 4'd2;
    if (c inside {[8'h4b:8'h4d]}) return 4'd3;
    if (c inside {[8'h4e:8'h51]}) return 4'd4;
    if (c inside {[8'h52:8'h54]}) return 4'd5;
    if (c inside {[8'h55:8'h57]}) return 4'd6;
    if (c inside {[8'h58:8'h5a]}) return 4'd7;
    return OtherBank;
  endfunction

endpackage

/* sv/banked_sorted_name_table_unit.sv */
// Channel   | Ports                                           | Handshake
// request   | req_type name_hi name_mid name_lo entry_value   | start && !busy
// result    | status position bank_fill bank_id               | done, one cycle
//
// A request scans its bank through an entry memory with a registered read, each entry
// checked in a read state and then a compare state. It then shifts the tail, each moved
// entry read, then written back, with a last check in S_SHRD. A busy request ends in S_FIN.
// An insert into a full bank never raises busy, and an empty bank raises it for one cycle.
// Synchronous reset clears the bank counts; the entry memory is not cleared. The
// receiver cannot stall: done pulses once per request, in the cycle in which busy
// drops, or with busy never raised for an insert into a full bank.
module banked_sorted_name_table_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       req_type,
  input  logic [63:0]                name_hi,
  input  logic [63:0]                name_mid,
  input  logic [31:0]                name_lo,
  input  logic [31:0]                entry_value,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [bsnt_pkg::PosW-1:0]  position,
  output logic [bsnt_pkg::CntW-1:0]  bank_fill,
  output logic [bsnt_pkg::BankW-1:0] bank_id
);
  import bsnt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CMP   = 6'b000100,
    S_SHRD  = 6'b001000,
    S_SHWR  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state;
  entry_t mem [TotalEntries];
  entry_t rdata;
  logic [CntW-1:0] counts [NumBanks];

  logic            op_rm;
  logic [159:0]    key;
  logic [31:0]     val;
  logic [BankW-1:0] bank;
  logic [AddrW-1:0] base;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] pos;
  logic [CntW-1:0] shi;
  logic            found;
  entry_t          hold;

  logic            we;
  logic [AddrW-1:0] waddr;
  entry_t          wdata;
  logic            re;
  logic [AddrW-1:0] raddr;

  logic [159:0]    key_in;
  logic [BankW-1:0] bank_in;
  logic            le;
  logic            vmatch;

  assign key_in  = clean_name({name_hi, name_mid, name_lo});
  assign bank_in = pick_bank(key_in[159:152]);
  assign le      = rdata[EntryW-1 -: 160] <= key;
  assign vmatch  = rdata[31:0] == val;
  assign busy    = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    re = 1'b0;
    raddr = base + AddrW'(idx);
    we = 1'b0;
    waddr = base + AddrW'(shi);
    wdata = hold;
    case (state)
      S_RD: re = 1'b1;
      S_SHRD: begin
        re = 1'b1;
        // Insert reads the entry below the slot; remove reads the one above.
        raddr = op_rm ? base + AddrW'(shi) + AddrW'(1) : base + AddrW'(shi) - AddrW'(1);
      end
      S_SHWR: begin
        we = 1'b1;
        wdata = rdata;
      end
      S_FIN: begin
        we = !op_rm && !found;
        waddr = base + AddrW'(pos);
        wdata = {key, val};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      for (int b = 0; b < NumBanks; b++) counts[b] <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_rm <= req_type;
            key <= key_in;
            val <= entry_value;
            bank <= bank_in;
            base <= AddrW'(bank_in) * AddrW'(EntriesPerBank);
            cnt <= counts[bank_in];
            idx <= '0;
            found <= 1'b0;
            if (!req_type && counts[bank_in] >= CntW'(EntriesPerBank)) begin
              status <= ST_FULL;
              position <= '0;
              bank_fill <= counts[bank_in];
              bank_id <= bank_in;
              done <= 1'b1;
            end else if (counts[bank_in] == '0) begin
              pos <= '0;
              state <= S_FIN;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (op_rm ? vmatch : !le) begin
            pos <= idx;
            found <= op_rm;
            shi <= op_rm ? idx : cnt;
            state <= S_SHRD;
          end else if (idx + CntW'(1) == cnt) begin
            pos <= cnt;
            shi <= cnt;
            state <= op_rm ? S_FIN : S_SHRD;
          end else begin
            idx <= idx + CntW'(1);
            state <= S_RD;
          end
        end
        S_SHRD: begin
          if (op_rm ? (shi + CntW'(1) >= cnt) : (shi == pos)) begin
            state <= S_FIN;
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          shi <= op_rm ? shi + CntW'(1) : shi - CntW'(1);
          state <= S_SHRD;
        end
        S_FIN: begin
          state <= S_IDLE;
          done <= 1'b1;
          bank_id <= bank;
          if (!op_rm) begin
            counts[bank] <= cnt + CntW'(1);
            bank_fill <= cnt + CntW'(1);
            status <= ST_INSERTED;
            position <= PosW'(pos);
          end else if (found) begin
            counts[bank] <= cnt - CntW'(1);
            bank_fill <= cnt - CntW'(1);
            status <= ST_REMOVED;
            position <= PosW'(pos);
          end else begin
            bank_fill <= cnt;
            status <= ST_NOT_FOUND;
            position <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign hold = {key, val};

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> state == S_IDLE)
    else $error("result while busy");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
      done |-> bank_fill <= CntW'(EntriesPerBank))
    else $error("bank fill out of range");
  a_full_nochange: assert property (@(posedge clk) disable iff (rst)
      done && status == ST_FULL |-> position == '0)
    else $error("full request with position");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
      state == S_IDLE |-> !we)
    else $error("memory write while idle");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import bsnt_pkg::*;

  localparam bit REQ_INSERT = 1'b0;
  localparam bit REQ_REMOVE = 1'b1;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 250;

  typedef struct {
    status_t            st;
    logic [PosW-1:0]    pos;
    logic [CntW-1:0]    fill;
    logic [BankW-1:0]   bank;
  } table_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              req_type = 1'b0;
  logic [63:0]       name_hi = '0;
  logic [63:0]       name_mid = '0;
  logic [31:0]       name_lo = '0;
  logic [31:0]       entry_value = '0;
  logic              done;
  logic [1:0]        status;
  logic [PosW-1:0]   position;
  logic [CntW-1:0]   bank_fill;
  logic [BankW-1:0]  bank_id;

  // Shadow copy of the table contents.
  logic [159:0]      shadow_name [NumBanks][EntriesPerBank];
  logic [31:0]       shadow_value [NumBanks][EntriesPerBank];
  int                shadow_count [NumBanks];

  table_result_t     pending_results [$];
  int                idle_pct = 0;
  int                mismatches = 0;
  int                idle_cycles = 0;
  int                n_status [4];

  always #5 clk = ~clk;

  banked_sorted_name_table_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .name_hi(name_hi), .name_mid(name_mid),
    .name_lo(name_lo), .entry_value(entry_value),
    .done(done), .status(status), .position(position),
    .bank_fill(bank_fill), .bank_id(bank_id)
  );

  function automatic logic [159:0] terminate_name(input logic [159:0] raw);
    logic [159:0] keep;
    keep = '1;
    for (int b = 19; b >= 0; b--) begin
      if (raw[8*b +: 8] == 8'd0) begin
        keep = ~((160'd1 << (8*b)) - 160'd1);
        break;
      end
    end
    return raw & keep;
  endfunction

  function automatic logic [BankW-1:0] bank_of(input logic [7:0] first);
    logic [7:0] up;
    up = (first >= "a" && first <= "z") ? first - 8'h20 : first;
    case (up) inside
      ["A":"C"]: return 4'd0;
      ["D":"F"]: return 4'd1;
      ["G":"J"]: return 4'd2;
      ["K":"M"]: return 4'd3;
      ["N":"Q"]: return 4'd4;
      ["R":"T"]: return 4'd5;
      ["U":"W"]: return 4'd6;
      ["X":"Z"]: return 4'd7;
      default:   return OtherBank;
    endcase
  endfunction

  function automatic table_result_t apply_to_shadow(input bit rt, input logic [159:0] raw,
                                                    input logic [31:0] val);
    table_result_t r;
    logic [159:0] nm;
    int b, cnt, p;
    nm = terminate_name(raw);
    b = int'(bank_of(nm[159:152]));
    cnt = shadow_count[b];
    p = 0;
    if (rt == REQ_INSERT) begin
      if (cnt >= EntriesPerBank) begin
        r.st = ST_FULL;
      end else begin
        while (p < cnt && shadow_name[b][p] <= nm) p++;
        for (int i = cnt; i > p; i--) begin
          shadow_name[b][i] = shadow_name[b][i-1];
          shadow_value[b][i] = shadow_value[b][i-1];
        end
        shadow_name[b][p] = nm;
        shadow_value[b][p] = val;
        cnt++;
        r.st = ST_INSERTED;
      end
    end else begin
      r.st = ST_NOT_FOUND;
      for (int i = 0; i < cnt; i++) begin
        if (shadow_value[b][i] == val) begin
          p = i;
          r.st = ST_REMOVED;
          break;
        end
      end
      if (r.st == ST_REMOVED) begin
        for (int i = p; i + 1 < cnt; i++) begin
          shadow_name[b][i] = shadow_name[b][i+1];
          shadow_value[b][i] = shadow_value[b][i+1];
        end
        cnt--;
      end
    end
    shadow_count[b] = cnt;
    r.pos = p[PosW-1:0];
    r.fill = cnt[CntW-1:0];
    r.bank = b[BankW-1:0];
    return r;
  endfunction

  function automatic logic [159:0] text_name(input string s);
    logic [159:0] n;
    n = '0;
    for (int i = 0; i < s.len() && i < 20; i++) n[159-8*i -: 8] = s[i];
    return n;
  endfunction

  // Random name: chosen first byte, random non-zero body, optional junk after the end.
  function automatic logic [159:0] random_name(input logic [7:0] first);
    logic [159:0] n;
    int len;
    len = $urandom_range(20, 1);
    n = {$urandom, $urandom, $urandom, $urandom, $urandom};
    for (int i = 1; i < len; i++)
      if (n[159-8*i -: 8] == 8'd0) n[159-8*i -: 8] = 8'h41;
    n[159:152] = first;
    if (len < 20 && $urandom_range(3) != 0) n[159-8*len -: 8] = 8'd0;
    if (len < 20 && $urandom_range(1) == 0)
      for (int i = len; i < 20; i++) n[159-8*i -: 8] = 8'd0;
    return n;
  endfunction

  task automatic send_request(input bit rt, input logic [159:0] nm, input logic [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req_type <= rt;
    {name_hi, name_mid, name_lo} <= nm;
    entry_value <= val;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_to_shadow(rt, nm, val));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    string firsts;
    firsts = "DGKNRUXdgknrux";
    idle_pct = 0;
    send_request(REQ_REMOVE, text_name("Apple"), 32'd1);
    send_request(REQ_INSERT, text_name("Banana"), 32'd10);
    send_request(REQ_INSERT, text_name("apple"), 32'd11);
    send_request(REQ_INSERT, text_name("Banana"), 32'd12);
    send_request(REQ_INSERT, text_name("Ab"), 32'hFFFF_FFFF);
    send_request(REQ_INSERT, {"Ba", 8'h00, 136'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FF},
                 32'd13);
    send_request(REQ_INSERT, '1, 32'd0);
    send_request(REQ_INSERT, '0, 32'd0);
    send_request(REQ_INSERT, {8'h5B, 152'd0}, 32'd5);
    send_request(REQ_INSERT, {8'h40, 152'd0}, 32'd6);
    send_request(REQ_INSERT, text_name("ABCDEFGHIJKLMNOPQRST"), 32'd7);
    foreach (firsts[i])
      send_request(REQ_INSERT, {firsts[i], "z", 144'd0}, 32'(20 + i));
    send_request(REQ_REMOVE, text_name("Cxx"), 32'd12);
    send_request(REQ_REMOVE, text_name("c"), 32'd99);
    send_request(REQ_REMOVE, '0, 32'd0);
    send_request(REQ_REMOVE, text_name("A"), 32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_bank_full();
    idle_pct = 56;
    for (int i = 0; i < EntriesPerBank + 2; i++)
      send_request(REQ_INSERT, random_name($urandom_range(1) ? "Y" : "z"), 32'(1000 + i % 5));
    // Hold the next request off until the bank has settled.
    wait_drained();
    send_request(REQ_REMOVE, text_name("X"), 32'd1002);
    send_request(REQ_REMOVE, text_name("x"), 32'd7777);
    send_request(REQ_INSERT, text_name("Zz"), 32'd1);
    send_request(REQ_INSERT, text_name("Zz"), 32'd2);
  endtask

  task automatic test_random(input int pct, input int count);
    logic [7:0] first;
    logic [31:0] val;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7)
        first = 8'h41 + 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h20 : 8'h00);
      else
        first = 8'($urandom_range(255));
      val = ($urandom_range(1) == 0) ? 32'($urandom_range(15)) : $urandom;
      send_request($urandom_range(9) < 6 ? REQ_INSERT : REQ_REMOVE, random_name(first), val);
    end
  endtask

  always @(posedge clk) begin
    table_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d bank %0d", status, bank_id);
      end else begin
        exp_r = pending_results.pop_front();
        n_status[exp_r.st]++;
        if (status !== exp_r.st || position !== exp_r.pos || bank_fill !== exp_r.fill ||
            bank_id !== exp_r.bank) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d pos %0d fill %0d bank %0d, got %0d %0d %0d %0d",
                     exp_r.st, exp_r.pos, exp_r.fill, exp_r.bank,
                     status, position, bank_fill, bank_id);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (shadow_count[b]) shadow_count[b] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_bank_full();
    test_random(0, 75);
    test_random(56, 75);
    test_random(0, 75);
    test_random(10, 75);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered inserts %0d, removes %0d, misses %0d, full-bank rejects %0d",
             n_status[ST_INSERTED], n_status[ST_REMOVED], n_status[ST_NOT_FOUND],
             n_status[ST_FULL]);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/bsnt_pkg.sv
sv/banked_sorted_name_table_unit.sv
bench/tb_top.sv
